// ----- hdl/obrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_pkg
// Shared widths, operation codes and the result record of the byte ring buffer.
// ----------------------------------------------------------------------------
package obrb_pkg;

    // field widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned LEVEL_W  = 13;

    // stream word widths
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 48;

    // slot arithmetic width: head plus distance, room for a 17-bit head plus a 13-bit distance
    localparam int unsigned SLOT_SUM_W = 18;

    // reset capacity in bytes
    localparam logic [LEVEL_W-1:0] CAP_RESET = 13'd4096;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    // result record handed from the control stage to the output stage
    typedef struct packed {
        logic               accepted;
        logic               is_peek;
        logic [COUNT_W-1:0] popped;
        logic [LEVEL_W-1:0] fill;
        logic [LEVEL_W-1:0] free;
    } res_meta_t;

endpackage

// ----- hdl/offset_write_byte_ring_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// offset_write_byte_ring_buffer
// Circular byte store with offset writes, peeks, pops and clear.
//
//  channel  | dir | word layout (low bit first)
//  s_axis   | in  | tuser: mode[1:0]; tdata: offset[11:0], data_byte[19:12],
//           |     |        count[32:20], zero pad [39:33]
//  m_axis   | out | tdata: accepted[0], read_byte[8:1], popped[21:9],
//           |     |        fill_level[34:22], free_space[47:35]
//  cfg      | in  | cfg_we, cfg_wdata = capacity_limit
//
// One word per cycle sustained while m_axis does not stall; the accepting edge does
// the memory access and registers the result record, then the output register raises m_tvalid.
// The single memory port is the limit: one byte access per word.
// Reset clears head and fill and sets capacity to 4096; stored bytes are kept.
// A stall on m_axis backs up through the result stage into s_tready.
// ----------------------------------------------------------------------------
module offset_write_byte_ring_buffer
    import obrb_pkg::*;
#(
    parameter int unsigned DEPTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [LEVEL_W-1:0]    cfg_wdata,    // capacity_limit
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,      // offset, data_byte, count, pad
    input  logic [IN_USER_W-1:0]  s_tuser,      // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata       // accepted, read_byte, popped,
                                                // fill_level, free_space
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic              accept;
    logic              mem_en;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_rdata;
    logic              res_valid;
    res_meta_t         res_meta;
    logic              res_take;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [BYTE_W-1:0]     rbyte;

    // move the result on when the output register is free or draining
    assign res_take = res_valid && (!out_valid_reg || m_tready);
    assign s_tready = !res_valid || res_take;
    assign accept   = s_tvalid && s_tready;

    obrb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .mode      (s_tuser[MODE_W-1:0]),
        .offset    (s_tdata[11:0]),
        .count     (s_tdata[32:20]),
        .res_take  (res_take),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .res_valid (res_valid),
        .res_meta  (res_meta)
    );

    obrb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (s_tdata[19:12]),
        .rdata (mem_rdata)
    );

    // pass the byte only for a peek that found one
    assign rbyte = (res_meta.is_peek && res_meta.accepted) ? mem_rdata : '0;

    // load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {res_meta.free, res_meta.fill, res_meta.popped,
                              rbyte, res_meta.accepted};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hdl/obrb_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_store
// Single-port byte memory with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module obrb_store
    import obrb_pkg::*;
#(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [AW-1:0]     addr,
    input  logic [BYTE_W-1:0] wdata,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // write or read the addressed byte; hold read data otherwise
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/obrb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_ctrl
// Head, fill and capacity registers; decodes one operation per accepted word,
// drives the byte memory and registers the result record.
// ----------------------------------------------------------------------------
module obrb_ctrl
    import obrb_pkg::*;
#(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LEVEL_W-1:0]  cfg_wdata,
    input  logic                accept,
    input  logic [MODE_W-1:0]   mode,
    input  logic [OFFSET_W-1:0] offset,
    input  logic [COUNT_W-1:0]  count,
    input  logic                res_take,
    output logic                mem_en,
    output logic                mem_we,
    output logic [AW-1:0]       mem_addr,
    output logic                res_valid,
    output res_meta_t           res_meta
);

    localparam logic [16:0]           DEPTH_W   = 17'(DEPTH);
    localparam logic [SLOT_SUM_W-1:0] DEPTH_SUM = SLOT_SUM_W'(DEPTH);

    logic [LEVEL_W-1:0]    cap_reg;
    logic [AW-1:0]         head_reg, head_next;
    logic [LEVEL_W-1:0]    fill_reg, fill_next;
    logic                  res_valid_reg, res_valid_next;
    res_meta_t             meta_reg, meta_next;

    logic [LEVEL_W-1:0]    cap_use;
    logic [LEVEL_W-1:0]    off_ext;
    logic [LEVEL_W-1:0]    off_plus1;
    logic                  write_ok;
    logic                  peek_ok;
    logic [COUNT_W-1:0]    pop_cnt;
    logic [COUNT_W-1:0]    slot_dist;
    logic [SLOT_SUM_W-1:0] slot_sum;
    logic [SLOT_SUM_W-1:0] slot_wrap;
    logic [AW-1:0]         slot;

    // capacity in use is the smaller of the register and the memory depth
    assign cap_use = ({4'b0, cap_reg} < DEPTH_W) ? cap_reg : DEPTH_W[LEVEL_W-1:0];

    assign off_ext   = {1'b0, offset};
    assign off_plus1 = off_ext + 13'd1;
    assign write_ok  = (mode == MODE_WRITE) && (off_ext < cap_use);
    assign peek_ok   = (mode == MODE_PEEK) && (off_ext < fill_reg);
    assign pop_cnt   = (count < fill_reg) ? count : fill_reg;

    // shared slot adder: head plus distance, folded once around the depth
    assign slot_dist = (mode == MODE_POP) ? pop_cnt : off_ext;
    assign slot_sum  = SLOT_SUM_W'(head_reg) + SLOT_SUM_W'(slot_dist);
    assign slot_wrap = (slot_sum >= DEPTH_SUM) ? (slot_sum - DEPTH_SUM) : slot_sum;
    assign slot      = slot_wrap[AW-1:0];

    // memory access for a write in range or a peek below fill
    assign mem_en   = accept && (write_ok || peek_ok);
    assign mem_we   = write_ok;
    assign mem_addr = slot;

    // update head and fill, build the result record
    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        res_valid_next = res_valid_reg;
        meta_next      = meta_reg;
        if (res_take)
        begin
            res_valid_next = 1'b0;
        end
        if (accept)
        begin
            case (mode)
                MODE_WRITE:
                begin
                    if (write_ok && (off_plus1 > fill_reg))
                    begin
                        fill_next = off_plus1;
                    end
                end
                MODE_PEEK:
                begin
                    fill_next = fill_reg;
                end
                MODE_POP:
                begin
                    head_next = slot;
                    fill_next = fill_reg - pop_cnt;
                end
                MODE_CLEAR:
                begin
                    head_next = '0;
                    fill_next = '0;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
            res_valid_next    = 1'b1;
            meta_next.accepted = write_ok || peek_ok;
            meta_next.is_peek  = (mode == MODE_PEEK);
            meta_next.popped   = (mode == MODE_POP) ? pop_cnt : '0;
            meta_next.fill     = fill_next;
            meta_next.free     = (cap_use > fill_next) ? (cap_use - fill_next) : '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result record payload
    always_ff @(posedge clk)
    begin
        meta_reg <= meta_next;
    end

    assign res_valid = res_valid_reg;
    assign res_meta  = meta_reg;

endmodule
